// File: rtl/bpe_pkg.sv
// Shared types and constants for the Bezier point evaluator.
package bpe_pkg;

    localparam int MAX_POINTS_DEF  = 8;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int T_FRAC_BITS_DEF = 16;

    localparam int IDX_W = 3;
    localparam int CNT_W = 4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    // Strobes from the sequencer to every cell of the row
    typedef struct packed {
        logic load;
        logic mul;
        logic add;
    } cell_ctrl_t;

    // Status from the sequencer to the top level
    typedef struct packed {
        logic busy;
        logic out_load;
    } seq_status_t;

endpackage

// File: rtl/bpe_cell.sv
// One cell of the de Casteljau row: holds one working point and blends it with its neighbor.
module bpe_cell
    import bpe_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  logic                                         clk,
    input  cell_ctrl_t                                   ctrl,
    input  logic        [T_FRAC_BITS:0]                  t,
    input  logic signed [COORD_WIDTH-1:0]                load_x,
    input  logic signed [COORD_WIDTH-1:0]                load_y,
    input  logic signed [COORD_WIDTH+T_FRAC_BITS-1:0]    nb_x,
    input  logic signed [COORD_WIDTH+T_FRAC_BITS-1:0]    nb_y,
    output logic signed [COORD_WIDTH+T_FRAC_BITS-1:0]    w_x,
    output logic signed [COORD_WIDTH+T_FRAC_BITS-1:0]    w_y
);

    localparam int VW = COORD_WIDTH + T_FRAC_BITS;
    localparam int PW = VW + T_FRAC_BITS + 3;

    logic signed [VW-1:0]          w_x_reg, w_y_reg;
    logic signed [VW-1:0]          w_x_next, w_y_next;
    logic signed [PW-1:0]          p_x_reg, p_y_reg;
    logic signed [PW-1:0]          p_x_next, p_y_next;
    logic signed [VW:0]            d_x, d_y;
    logic signed [T_FRAC_BITS+1:0] ts;
    logic signed [PW-1:0]          s_x, s_y;

    assign ts = {1'b0, t};

    always_comb
    begin
        d_x      = (VW+1)'(nb_x) - (VW+1)'(w_x_reg);
        d_y      = (VW+1)'(nb_y) - (VW+1)'(w_y_reg);
        p_x_next = d_x * ts;
        p_y_next = d_y * ts;
        // arithmetic shift gives floor of the scaled difference
        s_x      = PW'(w_x_reg) + (p_x_reg >>> T_FRAC_BITS);
        s_y      = PW'(w_y_reg) + (p_y_reg >>> T_FRAC_BITS);
        w_x_next = s_x[VW-1:0];
        w_y_next = s_y[VW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            w_x_reg <= {load_x, {T_FRAC_BITS{1'b0}}};
            w_y_reg <= {load_y, {T_FRAC_BITS{1'b0}}};
        end
        else if (ctrl.add)
        begin
            w_x_reg <= w_x_next;
            w_y_reg <= w_y_next;
        end
        if (ctrl.mul)
        begin
            p_x_reg <= p_x_next;
            p_y_reg <= p_y_next;
        end
    end

    assign w_x = w_x_reg;
    assign w_y = w_y_reg;

endmodule

// File: rtl/bpe_seq.sv
// Sequencer: steps the cell row through multiply and add phases, one pair per curve level.
module bpe_seq
    import bpe_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             eval_go,
    input  logic [CNT_W-1:0] point_count,
    input  logic             out_free,
    output cell_ctrl_t       cell_ctrl,
    output seq_status_t      status
);

    localparam int LW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DONE
    } state_t;

    state_t          state_reg;
    logic [LW-1:0]   lvl_reg;
    logic [CNT_W:0]  cnt_sat;
    logic [LW-1:0]   levels;

    // clamp the point count to one .. MAX_POINTS
    always_comb
    begin
        priority if (int'(point_count) > MAX_POINTS)
            cnt_sat = (CNT_W+1)'(MAX_POINTS);
        else if (point_count == '0)
            cnt_sat = (CNT_W+1)'(1);
        else
            cnt_sat = {1'b0, point_count};
        levels = LW'(cnt_sat - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lvl_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (eval_go)
                    begin
                        lvl_reg   <= levels;
                        state_reg <= (levels == '0) ? S_DONE : S_MUL;
                    end
                end
                S_MUL:
                    state_reg <= S_ADD;
                S_ADD:
                begin
                    lvl_reg   <= lvl_reg - 1'b1;
                    state_reg <= (lvl_reg == LW'(1)) ? S_DONE : S_MUL;
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign cell_ctrl.load  = eval_go;
    assign cell_ctrl.mul   = (state_reg == S_MUL);
    assign cell_ctrl.add   = (state_reg == S_ADD);
    assign status.busy     = (state_reg != S_IDLE);
    assign status.out_load = (state_reg == S_DONE) && out_free;

endmodule

// File: rtl/bezier_point_eval.sv
// Top level of the Bezier point evaluator: point store, cell row, sequencer, output register.
//
//  channel | handshake           | word
//  --------+---------------------+-----------------------------------------------------
//  in      | in_valid / in_stall | action, point_index, point_x, point_y,
//          |                     | t_fraction, point_count
//  out     | out_valid/out_stall | curve_x, curve_y
//
// A write word gives no result. An evaluate word with n points (count clamped to
// 1 .. MAX_POINTS) is accepted, then runs a multiply step and an add step in every cell
// for each of the n-1 curve levels, then a done step hands the point to the output
// register. The input stalls while the sequencer is busy, up to that handover.
// Reset clears the sequencer and the output valid; the point store comes up unknown
// and must be written before it is evaluated. A stalled result holds in the output
// register while write words are still taken; a finished evaluation waits in the done
// state until the register frees.
module bezier_point_eval
    import bpe_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic        [IDX_W-1:0]       point_index,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic        [T_FRAC_BITS:0]   t_fraction,
    input  logic        [CNT_W-1:0]       point_count,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] curve_x,
    output logic signed [COORD_WIDTH-1:0] curve_y
);

    localparam int VW = COORD_WIDTH + T_FRAC_BITS;
    localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    logic signed [COORD_WIDTH-1:0] store_x_reg [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] store_y_reg [MAX_POINTS];
    logic signed [VW-1:0]          w_x [MAX_POINTS];
    logic signed [VW-1:0]          w_y [MAX_POINTS];

    logic [T_FRAC_BITS:0]          t_reg;
    logic                          in_take;
    logic                          wr_go;
    logic                          eval_go;
    logic                          out_free;
    cell_ctrl_t                    cell_ctrl;
    seq_status_t                   status;

    logic                          out_valid_reg;
    logic signed [COORD_WIDTH-1:0] curve_x_reg, curve_y_reg;
    logic signed [COORD_WIDTH-1:0] curve_x_next, curve_y_next;

    // take words only while the row is free
    assign in_stall = status.busy;
    assign in_take  = in_valid && !in_stall;
    assign wr_go    = in_take && (action == ACT_WRITE);
    assign eval_go  = in_take && (action == ACT_EVAL);
    assign out_free = !out_valid_reg || !out_stall;

    // point store: one entry per slot, written slots beyond the store are dropped
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_store
        always_ff @(posedge clk)
        begin
            if (wr_go && (int'(point_index) == i))
            begin
                store_x_reg[i] <= point_x;
                store_y_reg[i] <= point_y;
            end
        end
    end

    // hold t for the whole evaluation, saturated at one
    always_ff @(posedge clk)
    begin
        if (eval_go)
            t_reg <= (t_fraction > T_ONE) ? T_ONE : t_fraction;
    end

    bpe_seq #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .eval_go     (eval_go),
        .point_count (point_count),
        .out_free    (out_free),
        .cell_ctrl   (cell_ctrl),
        .status      (status)
    );

    // row of cells: every level, cell i blends its point with cell i+1's;
    // after the last level cell 0 holds the curve point
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_row
        logic signed [VW-1:0] nb_x, nb_y;

        if (i == MAX_POINTS - 1)
        begin : g_tail
            assign nb_x = w_x[i];
            assign nb_y = w_y[i];
        end
        else
        begin : g_link
            assign nb_x = w_x[i+1];
            assign nb_y = w_y[i+1];
        end

        bpe_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .T_FRAC_BITS (T_FRAC_BITS)
        ) u_cell (
            .clk    (clk),
            .ctrl   (cell_ctrl),
            .t      (t_reg),
            .load_x (store_x_reg[i]),
            .load_y (store_y_reg[i]),
            .nb_x   (nb_x),
            .nb_y   (nb_y),
            .w_x    (w_x[i]),
            .w_y    (w_y[i])
        );
    end

    // drop the fraction, rounding negative values up toward zero
    always_comb
    begin
        curve_x_next = w_x[0][VW-1:T_FRAC_BITS];
        curve_y_next = w_y[0][VW-1:T_FRAC_BITS];
        if (w_x[0][VW-1] && (w_x[0][T_FRAC_BITS-1:0] != '0))
            curve_x_next = curve_x_next + 1'b1;
        if (w_y[0][VW-1] && (w_y[0][T_FRAC_BITS-1:0] != '0))
            curve_y_next = curve_y_next + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (status.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (status.out_load)
        begin
            curve_x_reg <= curve_x_next;
            curve_y_reg <= curve_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign curve_x   = curve_x_reg;
    assign curve_y   = curve_y_reg;

endmodule

// File: rtl/bpe_checker.sv
// Port-level checks for the Bezier point evaluator, bound to the top level.
module bpe_checker
    import bpe_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          action,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [COORD_WIDTH-1:0] curve_x,
    input logic signed [COORD_WIDTH-1:0] curve_y
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(curve_x) && $stable(curve_y))
        else $error("stalled result changed or vanished");

    // an accepted evaluate word busies the block
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ACT_EVAL) |=> in_stall)
        else $error("evaluate word did not stall the input");

    // a write word never makes a result
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ACT_WRITE) && !out_valid |=> !out_valid)
        else $error("write word produced a result");

    // a result appears only at the end of an evaluation
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while the block was idle");

endmodule

bind bezier_point_eval bpe_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_bpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .curve_x   (curve_x),
    .curve_y   (curve_y)
);
